>>> rtl/core/dtl_pkg.sv
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared types and constants for the debounced toggle latching relay driver.
// ----------------------------------------------------------------------------
package dtl_pkg;

   localparam int NUM_INPUTS = 4;
   localparam int NUM_RELAYS = 3;
   localparam int CLEAR_BTN  = NUM_INPUTS - 1;
   localparam int TOGGLE_N   = (NUM_RELAYS < CLEAR_BTN) ? NUM_RELAYS : CLEAR_BTN;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int HOLD_W      = 8;
   localparam int PULSE_W     = 16;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTORE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_HOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_HOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTORE    = 3'd4;

   typedef logic [NUM_INPUTS-1:0] in_vec_type;
   typedef logic [NUM_RELAYS-1:0] relay_vec_type;

   typedef struct packed {
      logic [HOLD_W-1:0]     rise_hold;
      logic [HOLD_W-1:0]     fall_hold;
      logic [PULSE_W-1:0]    pulse_ticks;
      logic [HOLD_W-1:0]     long_press;
      relay_vec_type         restore;
   } cfg_type;

   typedef struct packed {
      logic              stable;
      logic              flag;
      logic [HOLD_W-1:0] count;
   } deb_type;

   typedef struct packed {
      logic               level;
      logic               ptarget;
      logic [PULSE_W-1:0] timer;
      logic               set_drv;
      logic               rst_drv;
   } coil_type;

endpackage

>>> rtl/core/dtl_ifs.sv
// ----------------------------------------------------------------------------
// dtl interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface dtl_req_if;
   logic                   valid;
   logic                   ready;
   logic                   command;
   dtl_pkg::in_vec_type    raw_inputs;

   modport source (output valid, output command, output raw_inputs, input ready);
   modport sink   (input valid, input command, input raw_inputs, output ready);
endinterface

interface dtl_rsp_if;
   logic                   valid;
   logic                   ready;
   dtl_pkg::relay_vec_type set_coils;
   dtl_pkg::relay_vec_type reset_coils;
   dtl_pkg::relay_vec_type relay_levels;
   dtl_pkg::in_vec_type    clean_inputs;
   logic                   persist_valid;
   dtl_pkg::relay_vec_type persist_targets;

   modport source (output valid, output set_coils, output reset_coils,
                   output relay_levels, output clean_inputs, output persist_valid,
                   output persist_targets, input ready);
   modport sink   (input valid, input set_coils, input reset_coils,
                   input relay_levels, input clean_inputs, input persist_valid,
                   input persist_targets, output ready);
endinterface

interface dtl_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dtl_pkg::CSR_INDEX_W-1:0]     index;
   logic [dtl_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/dtl_debounce.sv
// ----------------------------------------------------------------------------
// dtl_debounce
// One debounce lane: separate rise and fall hold counts, saturating counter.
// ----------------------------------------------------------------------------
module dtl_debounce (
   input  logic                      raw,
   input  dtl_pkg::deb_type          cur,
   input  logic [dtl_pkg::HOLD_W-1:0] rise_hold,
   input  logic [dtl_pkg::HOLD_W-1:0] fall_hold,
   output dtl_pkg::deb_type          nxt
);
   logic [dtl_pkg::HOLD_W-1:0] hold;
   logic [dtl_pkg::HOLD_W-1:0] cnt_inc;

   assign hold    = cur.stable ? fall_hold : rise_hold;
   assign cnt_inc = (cur.count == '1) ? cur.count : cur.count + 1'b1;

   always_comb begin
      nxt = cur;
      if (raw != cur.stable) begin
         if (cnt_inc > hold) begin
            nxt.stable = raw;
            nxt.flag   = raw;
            nxt.count  = '0;
         end else begin
            nxt.count = cnt_inc;
         end
      end else begin
         nxt.count = '0;
      end
   end
endmodule

>>> rtl/core/dtl_button.sv
// ----------------------------------------------------------------------------
// dtl_button
// Button logic: toggles from rise flags, long press of the clear button.
// ----------------------------------------------------------------------------
module dtl_button (
   input  dtl_pkg::in_vec_type        clean,
   input  dtl_pkg::in_vec_type        flags_in,
   input  dtl_pkg::relay_vec_type     targets_in,
   input  logic [dtl_pkg::HOLD_W-1:0] hold_in,
   input  logic [dtl_pkg::HOLD_W-1:0] long_press,
   output dtl_pkg::in_vec_type        flags_out,
   output dtl_pkg::relay_vec_type     targets_out,
   output logic [dtl_pkg::HOLD_W-1:0] hold_out,
   output logic                       changed
);
   always_comb begin
      flags_out   = flags_in;
      targets_out = targets_in;
      hold_out    = hold_in;
      changed     = 1'b0;
      if (clean[dtl_pkg::CLEAR_BTN]) begin
         if (hold_in > long_press) begin
            if (flags_in[dtl_pkg::CLEAR_BTN]) begin
               targets_out                    = '0;
               changed                        = 1'b1;
               flags_out[dtl_pkg::CLEAR_BTN] = 1'b0;
            end
            hold_out = '0;
         end
         for (int i = 0; i < dtl_pkg::TOGGLE_N; i++) begin
            flags_out[i] = 1'b0;
         end
      end else begin
         hold_out = '0;
         for (int i = 0; i < dtl_pkg::TOGGLE_N; i++) begin
            if (flags_in[i]) begin
               targets_out[i] = ~targets_in[i];
               changed        = 1'b1;
               flags_out[i]   = 1'b0;
            end
         end
      end
   end
endmodule

>>> rtl/core/dtl_coil.sv
// ----------------------------------------------------------------------------
// dtl_coil
// One relay lane: set/reset coil pulse timer and settled relay state.
// ----------------------------------------------------------------------------
module dtl_coil (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        load,
   input  logic                        load_level,
   input  logic                        target,
   input  logic [dtl_pkg::PULSE_W-1:0] pulse_len,
   output dtl_pkg::coil_type           coil_in
);
   dtl_pkg::coil_type coil_ff;

   always_comb begin
      coil_in = coil_ff;
      if (step && !(target == coil_ff.level && coil_ff.ptarget == coil_ff.level)) begin
         if (coil_ff.timer == '0) begin
            if (target) begin
               coil_in.set_drv = 1'b1;
            end else begin
               coil_in.rst_drv = 1'b1;
            end
            coil_in.ptarget = target;
            coil_in.timer   = dtl_pkg::PULSE_W'(1);
         end else if (coil_ff.timer == pulse_len) begin
            if (coil_ff.ptarget) begin
               coil_in.set_drv = 1'b0;
            end else begin
               coil_in.rst_drv = 1'b0;
            end
            coil_in.level = coil_ff.ptarget;
            coil_in.timer = '0;
         end else begin
            coil_in.timer = coil_ff.timer + 1'b1;
         end
      end
      if (load) begin
         coil_in.level   = load_level;
         coil_in.ptarget = load_level;
         coil_in.timer   = '0;
         coil_in.set_drv = 1'b0;
         coil_in.rst_drv = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_ff <= '0;
      end else begin
         coil_ff <= coil_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_coil: assert property (@(posedge clock) disable iff (reset)
      !(coil_ff.set_drv && coil_ff.rst_drv))
      else $error("set and reset coil driven together");
   a_drive_timer: assert property (@(posedge clock) disable iff (reset)
      (coil_ff.set_drv || coil_ff.rst_drv) == (coil_ff.timer != '0))
      else $error("coil drive out of step with pulse timer");
`endif
endmodule

>>> rtl/core/debounced_toggle_latching_relay_driver.sv
// ----------------------------------------------------------------------------
// debounced_toggle_latching_relay_driver
// Debounces button inputs, toggles relay targets and pulses latching coils.
// ----------------------------------------------------------------------------
//  channel  | role | beat payload
//  req_bus  | in   | command, raw_inputs
//  rsp_bus  | out  | set/reset coils, relay levels, clean inputs, persist info
//  csr_bus  | in   | register index, write data (always ready)
//
//  One beat per cycle while rsp is not stalled; a req passes the input
//  register, then the state update and the result register.
//  A stalled rsp holds its result; one more req is taken into the input
//  register, then req_ready drops until rsp is taken.
//  Synchronous reset clears all but data registers, loads register defaults.
// ----------------------------------------------------------------------------
module debounced_toggle_latching_relay_driver #(
   parameter int PRESCALE = 10
) (
   input  logic          clock,
   input  logic          reset,
   dtl_req_if.sink       req_bus,
   dtl_rsp_if.source     rsp_bus,
   dtl_csr_if.sink       csr_bus
);
   localparam int PS_W = $clog2(PRESCALE + 1);

   dtl_pkg::cfg_type             cfg_ff;
   logic                         in_valid_ff;
   logic                         in_cmd_ff;
   dtl_pkg::in_vec_type          in_raw_ff;
   logic                         advance;
   logic                         tick;
   logic                         restore;

   logic [PS_W-1:0]              presc_ff;
   logic [PS_W-1:0]              presc_inc;
   logic [PS_W-1:0]              presc_in;
   logic [dtl_pkg::HOLD_W-1:0]   hold_ff;
   logic [dtl_pkg::HOLD_W-1:0]   hold_pre;
   logic [dtl_pkg::HOLD_W-1:0]   hold_in;
   dtl_pkg::deb_type             deb_ff  [dtl_pkg::NUM_INPUTS];
   dtl_pkg::deb_type             deb_nxt [dtl_pkg::NUM_INPUTS];
   dtl_pkg::in_vec_type          clean;
   dtl_pkg::in_vec_type          flags_deb;
   dtl_pkg::in_vec_type          flags_in;
   dtl_pkg::relay_vec_type       target_ff;
   dtl_pkg::relay_vec_type       target_btn;
   dtl_pkg::relay_vec_type       target_in;
   logic                         changed;
   logic [dtl_pkg::PULSE_W-1:0]  pulse_len;
   dtl_pkg::coil_type            coil_in [dtl_pkg::NUM_RELAYS];
   dtl_pkg::relay_vec_type       set_in;
   dtl_pkg::relay_vec_type       rst_in;
   dtl_pkg::relay_vec_type       lvl_in;
   logic                         rsp_valid_ff;

   function automatic dtl_pkg::in_vec_type clean_now();
      dtl_pkg::in_vec_type v;
      for (int i = 0; i < dtl_pkg::NUM_INPUTS; i++) begin
         v[i] = deb_ff[i].stable;
      end
      return v;
   endfunction

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_hold   <= dtl_pkg::HOLD_W'(20);
         cfg_ff.fall_hold   <= dtl_pkg::HOLD_W'(20);
         cfg_ff.pulse_ticks <= dtl_pkg::PULSE_W'(50);
         cfg_ff.long_press  <= dtl_pkg::HOLD_W'(200);
         cfg_ff.restore     <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            dtl_pkg::CSR_RISE_HOLD:  cfg_ff.rise_hold   <= csr_bus.data[dtl_pkg::HOLD_W-1:0];
            dtl_pkg::CSR_FALL_HOLD:  cfg_ff.fall_hold   <= csr_bus.data[dtl_pkg::HOLD_W-1:0];
            dtl_pkg::CSR_PULSE:      cfg_ff.pulse_ticks <= csr_bus.data[dtl_pkg::PULSE_W-1:0];
            dtl_pkg::CSR_LONG_PRESS: cfg_ff.long_press  <= csr_bus.data[dtl_pkg::HOLD_W-1:0];
            dtl_pkg::CSR_RESTORE:    cfg_ff.restore     <= csr_bus.data[dtl_pkg::NUM_RELAYS-1:0];
            default: ;
         endcase
      end
   end

   // input register
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign restore       = advance && (in_cmd_ff == dtl_pkg::CMD_RESTORE);
   assign tick          = advance && (in_cmd_ff == dtl_pkg::CMD_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_cmd_ff <= req_bus.command;
         in_raw_ff <= req_bus.raw_inputs;
      end
   end

   // prescaler and long-press units
   assign presc_inc = presc_ff + PS_W'(1);
   assign presc_in  = (presc_inc >= PS_W'(PRESCALE)) ? '0 : presc_inc;
   assign hold_pre  = (presc_inc >= PS_W'(PRESCALE)) ? hold_ff + 1'b1 : hold_ff;

   // debounce lanes
   for (genvar i = 0; i < dtl_pkg::NUM_INPUTS; i++) begin : g_deb
      dtl_debounce u_deb (
         .raw       (in_raw_ff[i]),
         .cur       (deb_ff[i]),
         .rise_hold (cfg_ff.rise_hold),
         .fall_hold (cfg_ff.fall_hold),
         .nxt       (deb_nxt[i])
      );
      assign clean[i]     = deb_nxt[i].stable;
      assign flags_deb[i] = deb_nxt[i].flag;

      always_ff @(posedge clock) begin
         if (reset) begin
            deb_ff[i] <= '0;
         end else if (tick) begin
            deb_ff[i] <= '{stable: deb_nxt[i].stable, flag: flags_in[i],
                           count: deb_nxt[i].count};
         end
      end
   end

   dtl_button u_button (
      .clean       (clean),
      .flags_in    (flags_deb),
      .targets_in  (target_ff),
      .hold_in     (hold_pre),
      .long_press  (cfg_ff.long_press),
      .flags_out   (flags_in),
      .targets_out (target_btn),
      .hold_out    (hold_in),
      .changed     (changed)
   );

   assign target_in = restore ? cfg_ff.restore : (tick ? target_btn : target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff  <= '0;
         hold_ff   <= '0;
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
         if (tick) begin
            presc_ff <= presc_in;
            hold_ff  <= hold_in;
         end
      end
   end

   // coil lanes
   assign pulse_len = (cfg_ff.pulse_ticks == '0) ? dtl_pkg::PULSE_W'(1) : cfg_ff.pulse_ticks;

   for (genvar r = 0; r < dtl_pkg::NUM_RELAYS; r++) begin : g_coil
      dtl_coil u_coil (
         .clock      (clock),
         .reset      (reset),
         .step       (tick),
         .load       (restore),
         .load_level (cfg_ff.restore[r]),
         .target     (target_btn[r]),
         .pulse_len  (pulse_len),
         .coil_in    (coil_in[r])
      );
      assign set_in[r] = coil_in[r].set_drv;
      assign rst_in[r] = coil_in[r].rst_drv;
      assign lvl_in[r] = coil_in[r].level;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bus.set_coils       <= set_in;
         rsp_bus.reset_coils     <= rst_in;
         rsp_bus.relay_levels    <= lvl_in;
         rsp_bus.clean_inputs    <= restore ? clean_now() : clean;
         rsp_bus.persist_valid   <= tick && changed;
         rsp_bus.persist_targets <= target_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_restore_levels: assert property (@(posedge clock) disable iff (reset)
      restore |=> (rsp_bus.relay_levels == $past(cfg_ff.restore)
                   && rsp_bus.persist_targets == $past(cfg_ff.restore)))
      else $error("restore did not load relay levels");
   a_no_persist_restore: assert property (@(posedge clock) disable iff (reset)
      restore |=> !rsp_bus.persist_valid)
      else $error("persist reported on restore");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_bus.ready)
      else $error("input stalled with empty result register");
`endif
endmodule

>>> test/debounced_toggle_latching_relay_driver_tb.sv
// ----------------------------------------------------------------------------
// debounced_toggle_latching_relay_driver_tb
// Drives tick and restore beats into the relay driver and checks every
// response beat against an in-bench model of the debouncer, the button
// logic and the coil pulse sequencer. The model is stepped as each request
// beat is accepted. Register settings are changed between phases while the
// block is idle. Both channel sides stall at random, and one phase holds off
// the response side long enough to back up the request side.
// ----------------------------------------------------------------------------
module debounced_toggle_latching_relay_driver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICK_PRESCALE  = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_BEATS = 150;
   localparam logic [dtl_pkg::CSR_INDEX_W-1:0] CSR_SPARE_BASE = 3'd5;

   typedef struct packed {
      dtl_pkg::relay_vec_type set_coils;
      dtl_pkg::relay_vec_type reset_coils;
      dtl_pkg::relay_vec_type relay_levels;
      dtl_pkg::in_vec_type    clean_inputs;
      logic                   persist_valid;
      dtl_pkg::relay_vec_type persist_targets;
   } drive_report_type;

   logic clock;
   logic reset;

   dtl_req_if req_bus ();
   dtl_rsp_if rsp_bus ();
   dtl_csr_if csr_bus ();

   debounced_toggle_latching_relay_driver #(
      .PRESCALE (TICK_PRESCALE)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // model of the block
   dtl_pkg::cfg_type             cfg_shadow;
   logic [3:0]                   tick_div;
   logic [dtl_pkg::HOLD_W-1:0]   press_units;
   dtl_pkg::deb_type             deb_lane [dtl_pkg::NUM_INPUTS];
   dtl_pkg::coil_type            coil_lane [dtl_pkg::NUM_RELAYS];
   dtl_pkg::relay_vec_type       relay_goal;

   drive_report_type    expected_reports [$];
   int                  mismatch_count;
   int                  quiet_cycles;
   bit                  calm;
   bit                  hold_request;
   int                  hold_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic drive_report_type step_relay_driver(input logic cmd,
                                                          input dtl_pkg::in_vec_type raw);
      drive_report_type             rep;
      logic                         changed;
      logic [dtl_pkg::PULSE_W-1:0]  len;
      logic [dtl_pkg::HOLD_W-1:0]   hold;
      changed = 1'b0;
      if (cmd == dtl_pkg::CMD_RESTORE) begin
         for (int r = 0; r < dtl_pkg::NUM_RELAYS; r++) begin
            relay_goal[r]         = cfg_shadow.restore[r];
            coil_lane[r].level    = cfg_shadow.restore[r];
            coil_lane[r].ptarget  = cfg_shadow.restore[r];
            coil_lane[r].timer    = '0;
            coil_lane[r].set_drv  = 1'b0;
            coil_lane[r].rst_drv  = 1'b0;
         end
      end else begin
         tick_div = tick_div + 4'd1;
         if (tick_div >= TICK_PRESCALE) begin
            tick_div    = '0;
            press_units = press_units + 1'b1;
         end
         for (int i = 0; i < dtl_pkg::NUM_INPUTS; i++) begin
            if (raw[i] != deb_lane[i].stable) begin
               hold = deb_lane[i].stable ? cfg_shadow.fall_hold : cfg_shadow.rise_hold;
               if (deb_lane[i].count != '1)
                  deb_lane[i].count = deb_lane[i].count + 1'b1;
               if (deb_lane[i].count > hold) begin
                  deb_lane[i].stable = raw[i];
                  deb_lane[i].flag   = raw[i];
                  deb_lane[i].count  = '0;
               end
            end else begin
               deb_lane[i].count = '0;
            end
         end
         if (deb_lane[dtl_pkg::CLEAR_BTN].stable) begin
            if (press_units > cfg_shadow.long_press) begin
               if (deb_lane[dtl_pkg::CLEAR_BTN].flag) begin
                  relay_goal = '0;
                  changed = 1'b1;
                  deb_lane[dtl_pkg::CLEAR_BTN].flag = 1'b0;
               end
               press_units = '0;
            end
            for (int i = 0; i < dtl_pkg::TOGGLE_N; i++)
               deb_lane[i].flag = 1'b0;
         end else begin
            press_units = '0;
            for (int i = 0; i < dtl_pkg::TOGGLE_N; i++) begin
               if (deb_lane[i].flag) begin
                  relay_goal[i] = ~relay_goal[i];
                  changed = 1'b1;
                  deb_lane[i].flag = 1'b0;
               end
            end
         end
         len = (cfg_shadow.pulse_ticks == '0) ? dtl_pkg::PULSE_W'(1) : cfg_shadow.pulse_ticks;
         for (int r = 0; r < dtl_pkg::NUM_RELAYS; r++) begin
            if (relay_goal[r] != coil_lane[r].level
                || coil_lane[r].ptarget != coil_lane[r].level) begin
               if (coil_lane[r].timer == '0) begin
                  if (relay_goal[r])
                     coil_lane[r].set_drv = 1'b1;
                  else
                     coil_lane[r].rst_drv = 1'b1;
                  coil_lane[r].ptarget = relay_goal[r];
                  coil_lane[r].timer   = dtl_pkg::PULSE_W'(1);
               end else if (coil_lane[r].timer == len) begin
                  if (coil_lane[r].ptarget)
                     coil_lane[r].set_drv = 1'b0;
                  else
                     coil_lane[r].rst_drv = 1'b0;
                  coil_lane[r].level = coil_lane[r].ptarget;
                  coil_lane[r].timer = '0;
               end else begin
                  coil_lane[r].timer = coil_lane[r].timer + 1'b1;
               end
            end
         end
      end
      for (int r = 0; r < dtl_pkg::NUM_RELAYS; r++) begin
         rep.set_coils[r]    = coil_lane[r].set_drv;
         rep.reset_coils[r]  = coil_lane[r].rst_drv;
         rep.relay_levels[r] = coil_lane[r].level;
      end
      for (int i = 0; i < dtl_pkg::NUM_INPUTS; i++)
         rep.clean_inputs[i] = deb_lane[i].stable;
      rep.persist_valid   = changed;
      rep.persist_targets = relay_goal;
      return rep;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // response side: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_BEATS;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 9);
         end
      end
   end

   always @(posedge clock) begin
      drive_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            $error("response beat with nothing expected");
         end else begin
            want = expected_reports.pop_front();
            check_field("set_coils", want.set_coils, rsp_bus.set_coils);
            check_field("reset_coils", want.reset_coils, rsp_bus.reset_coils);
            check_field("relay_levels", want.relay_levels, rsp_bus.relay_levels);
            check_field("clean_inputs", want.clean_inputs, rsp_bus.clean_inputs);
            check_field("persist_valid", want.persist_valid, rsp_bus.persist_valid);
            check_field("persist_targets", want.persist_targets, rsp_bus.persist_targets);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic cmd, input dtl_pkg::in_vec_type raw);
      while (!calm && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.raw_inputs <= raw;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      expected_reports.push_back(step_relay_driver(cmd, raw));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [dtl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dtl_pkg::CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      case (idx)
         dtl_pkg::CSR_RISE_HOLD:  cfg_shadow.rise_hold   = val[dtl_pkg::HOLD_W-1:0];
         dtl_pkg::CSR_FALL_HOLD:  cfg_shadow.fall_hold   = val[dtl_pkg::HOLD_W-1:0];
         dtl_pkg::CSR_PULSE:      cfg_shadow.pulse_ticks = val[dtl_pkg::PULSE_W-1:0];
         dtl_pkg::CSR_LONG_PRESS: cfg_shadow.long_press  = val[dtl_pkg::HOLD_W-1:0];
         dtl_pkg::CSR_RESTORE:    cfg_shadow.restore     = val[dtl_pkg::NUM_RELAYS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // upper data bits of the narrow fields are junk on purpose; one write goes to an unmapped index
   task automatic configure(input logic [7:0] rise, input logic [7:0] fall,
                            input logic [15:0] pulse, input logic [7:0] lng,
                            input dtl_pkg::relay_vec_type keep);
      write_reg(dtl_pkg::CSR_RISE_HOLD, {8'($urandom), rise});
      write_reg(dtl_pkg::CSR_FALL_HOLD, {8'($urandom), fall});
      write_reg(dtl_pkg::CSR_PULSE, pulse);
      write_reg(dtl_pkg::CSR_LONG_PRESS, {8'($urandom), lng});
      write_reg(dtl_pkg::CSR_RESTORE, {13'($urandom), keep});
      write_reg(CSR_SPARE_BASE + 3'($urandom_range(0, 2)), 16'($urandom));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_hold();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'($urandom_range(5, 12));
         default: return 8'($urandom_range(0, 3));
      endcase
   endfunction

   // button presses of random length around the debounce hold, with noise and restores mixed in
   task automatic run_sequences(input int n);
      int                  sent;
      int                  span;
      int                  dur;
      int                  pick;
      dtl_pkg::in_vec_type pattern;
      sent = 0;
      span = ((cfg_shadow.rise_hold > cfg_shadow.fall_hold) ?
              int'(cfg_shadow.rise_hold) : int'(cfg_shadow.fall_hold)) + 2;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_beat(dtl_pkg::CMD_RESTORE, dtl_pkg::in_vec_type'($urandom));
            sent++;
         end else if (pick < 16) begin
            repeat ($urandom_range(1, 6)) begin
               send_beat(dtl_pkg::CMD_TICK, dtl_pkg::in_vec_type'($urandom));
               sent++;
            end
         end else begin
            pick = $urandom_range(99);
            if (pick < 60)
               pattern = dtl_pkg::in_vec_type'(1) << $urandom_range(0, dtl_pkg::TOGGLE_N - 1);
            else if (pick < 85)
               pattern = (dtl_pkg::in_vec_type'(1) << dtl_pkg::CLEAR_BTN)
                         | dtl_pkg::in_vec_type'($urandom);
            else
               pattern = dtl_pkg::in_vec_type'($urandom);
            dur = (span > 40) ? $urandom_range(span - 10, span + 4) : $urandom_range(1, span + 2);
            if (pattern[dtl_pkg::CLEAR_BTN] && cfg_shadow.long_press < 6)
               dur += $urandom_range(0, (int'(cfg_shadow.long_press) + 2) * TICK_PRESCALE);
            repeat (dur) send_beat(dtl_pkg::CMD_TICK, pattern);
            sent += dur;
            dur = (span > 40) ? $urandom_range(span - 10, span + 4) : $urandom_range(1, span + 2);
            repeat (dur) send_beat(dtl_pkg::CMD_TICK, '0);
            sent += dur;
         end
      end
   endtask

   task automatic test_reset_values();
      send_beat(dtl_pkg::CMD_TICK, 4'hF);
      send_beat(dtl_pkg::CMD_TICK, 4'h0);
      send_beat(dtl_pkg::CMD_RESTORE, 4'hA);
      settle();
   endtask

   // zero holds and shortest pulse: toggles, clear press, long press
   task automatic test_fast_toggle();
      configure(8'd0, 8'd0, 16'd0, 8'd0, 3'b101);
      send_beat(dtl_pkg::CMD_RESTORE, 4'h0);
      send_beat(dtl_pkg::CMD_TICK, 4'b0001);
      send_beat(dtl_pkg::CMD_TICK, 4'b0000);
      send_beat(dtl_pkg::CMD_TICK, 4'b0001);
      send_beat(dtl_pkg::CMD_TICK, 4'b0110);
      send_beat(dtl_pkg::CMD_TICK, 4'b0000);
      send_beat(dtl_pkg::CMD_TICK, 4'b1111);
      repeat (12) send_beat(dtl_pkg::CMD_TICK, 4'b1000);
      send_beat(dtl_pkg::CMD_TICK, 4'b0000);
      send_beat(dtl_pkg::CMD_TICK, 4'b0010);
      send_beat(dtl_pkg::CMD_RESTORE, 4'h0);
      settle();
   endtask

   task automatic test_backpressure();
      configure(8'd0, 8'd0, 16'd3, 8'd1, 3'b011);
      send_beat(dtl_pkg::CMD_RESTORE, 4'h0);
      hold_request = 1'b1;
      repeat (40) send_beat(dtl_pkg::CMD_TICK, dtl_pkg::in_vec_type'($urandom));
      settle();
   endtask

   // phase 0: holds that never pass; phase 1: near-limit holds, longest pulse
   task automatic test_random_phases();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(8'd255, 8'd255, 16'd1, 8'd0, 3'b111);
            1: configure(8'd254, 8'd254, 16'hFFFF, 8'd255, 3'b010);
            default: configure(pick_hold(), pick_hold(), 16'($urandom_range(0, 6)),
                               8'($urandom_range(0, 3)), dtl_pkg::relay_vec_type'($urandom));
         endcase
         calm = (p == 6);
         send_beat(dtl_pkg::CMD_RESTORE, dtl_pkg::in_vec_type'($urandom));
         run_sequences((p < 2) ? 240 : 80);
         settle();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = dtl_pkg::CMD_TICK;
      req_bus.raw_inputs = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      calm               = 1'b0;
      hold_request       = 1'b0;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      cfg_shadow = '{rise_hold: 8'd20, fall_hold: 8'd20, pulse_ticks: 16'd50,
                     long_press: 8'd200, restore: '0};
      tick_div    = '0;
      press_units = '0;
      relay_goal  = '0;
      for (int i = 0; i < dtl_pkg::NUM_INPUTS; i++)
         deb_lane[i] = '0;
      for (int r = 0; r < dtl_pkg::NUM_RELAYS; r++)
         coil_lane[r] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_fast_toggle();
      test_backpressure();
      test_random_phases();

      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
rtl/core/dtl_pkg.sv
rtl/core/dtl_ifs.sv
rtl/core/dtl_debounce.sv
rtl/core/dtl_button.sv
rtl/core/dtl_coil.sv
rtl/core/debounced_toggle_latching_relay_driver.sv
test/debounced_toggle_latching_relay_driver_tb.sv
